### rtl/core/qpd_pkg.sv
// Shared types, character codes and hex decode for the quoted-printable decoder.
package qpd_pkg;

   localparam logic [7:0] EQ_CHAR = 8'h3D;
   localparam logic [7:0] CR_CHAR = 8'h0D;
   localparam logic [7:0] LF_CHAR = 8'h0A;
   localparam logic [15:0] TALLY_MAX = 16'hFFFF;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_NORMAL = 3'b001,
      PH_ESCAPE = 3'b010,
      PH_PAIR   = 3'b100
   } phase_type;

   // One classified item travelling from front to back.
   typedef struct packed {
      logic [7:0] value;
      logic       has_data;
      logic       bad_pair;
      logic       chunk_end;
   } op_type;

   // Returns {invalid, nibble}; invalid set when the byte is not a hex digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [4:0] res;
      res = 5'h10;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b0, 4'(ch - 8'h30)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         res = {1'b0, 4'(ch - 8'h41 + 8'd10)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         res = {1'b0, 4'(ch - 8'h61 + 8'd10)};
      end
      return res;
   endfunction

endpackage

### rtl/core/qpd_front.sv
// Front end: accepts bytes, tracks escape phase and decodes hex pairs.
module qpd_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [7:0]      req_in_byte,
   input  logic            req_chunk_end,
   input  logic            q_full,
   output logic            push,
   output qpd_pkg::op_type push_op
);

   qpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         held_ff;
   logic [4:0]         hi_dig, lo_dig;
   qpd_pkg::op_type    op;
   logic               accept;

   assign accept = req_valid && !q_full;
   assign hi_dig = qpd_pkg::hex_decode(held_ff);
   assign lo_dig = qpd_pkg::hex_decode(req_in_byte);

   always_comb begin
      op           = '0;
      op.chunk_end = req_chunk_end;
      phase_in     = phase_ff;
      unique case (phase_ff)
         qpd_pkg::PH_ESCAPE: begin
            if (req_in_byte != qpd_pkg::CR_CHAR) begin
               phase_in = (req_in_byte == qpd_pkg::LF_CHAR) ? qpd_pkg::PH_NORMAL
                                                            : qpd_pkg::PH_PAIR;
            end
         end
         qpd_pkg::PH_PAIR: begin
            if (hi_dig[4] || lo_dig[4]) begin
               op.bad_pair = 1'b1;
            end else begin
               op.has_data = 1'b1;
               op.value    = {hi_dig[3:0], lo_dig[3:0]};
            end
            phase_in = qpd_pkg::PH_NORMAL;
         end
         default: begin
            if (req_in_byte == qpd_pkg::EQ_CHAR) begin
               phase_in = qpd_pkg::PH_ESCAPE;
            end else begin
               op.has_data = 1'b1;
               op.value    = req_in_byte;
               phase_in    = qpd_pkg::PH_NORMAL;
            end
         end
      endcase
   end

   // Only items that produce a result go to the back end.
   assign push    = accept && (op.has_data || op.bad_pair || op.chunk_end);
   assign push_op = op;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qpd_pkg::PH_NORMAL;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= req_in_byte;
      end
   end

endmodule

### rtl/core/qpd_fifo.sv
// Two-entry queue of classified items between front and back end.
module qpd_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  qpd_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output qpd_pkg::op_type head_op
);

   localparam int unsigned PTR_W = $clog2(qpd_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(qpd_pkg::QUEUE_DEPTH + 1);

   qpd_pkg::op_type    mem_ff [qpd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(qpd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op   = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

### rtl/core/qpd_back.sv
// Back end: keeps the chunk error tally and drives the result register.
module qpd_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_not_empty,
   input  qpd_pkg::op_type head_op,
   output logic            pop,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_has_data,
   output logic            rsp_bad_pair,
   output logic            rsp_chunk_done,
   output logic [15:0]     rsp_chunk_errors
);

   logic        valid_ff;
   logic [15:0] tally_ff, tally_in, tally_next;
   logic [7:0]  byte_ff;
   logic        data_ff, bad_ff, done_ff;
   logic [15:0] errs_ff;

   assign pop = q_not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      tally_next = tally_ff;
      if (head_op.bad_pair && tally_ff != qpd_pkg::TALLY_MAX) begin
         tally_next = tally_ff + 16'd1;
      end
      tally_in = head_op.chunk_end ? 16'd0 : tally_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tally_ff <= 16'd0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            tally_ff <= tally_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff <= head_op.value;
         data_ff <= head_op.has_data;
         bad_ff  <= head_op.bad_pair;
         done_ff <= head_op.chunk_end;
         errs_ff <= head_op.chunk_end ? tally_next : 16'd0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_has_data     = data_ff;
   assign rsp_bad_pair     = bad_ff;
   assign rsp_chunk_done   = done_ff;
   assign rsp_chunk_errors = errs_ff;

endmodule

### rtl/core/quoted_printable_decoder_core.sv
// Quoted-printable decoder: one byte in per unstalled cycle, zero or one result out.
// A result is written to the queue at the edge that accepts its byte, then to the
// result register that drives rsp_.
// Throughput: one byte per cycle; a stalled result stalls the input once the
// two-entry queue is full.
// Reset clears the escape phase, held byte, error tally, queue and result valid.
module quoted_printable_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_chunk_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_has_data,
   output logic        rsp_bad_pair,
   output logic        rsp_chunk_done,
   output logic [15:0] rsp_chunk_errors
);

   logic            push, pop, q_full, q_not_empty;
   qpd_pkg::op_type push_op, head_op;

   assign req_stall = q_full;

   qpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_in_byte   (req_in_byte),
      .req_chunk_end (req_chunk_end),
      .q_full        (q_full),
      .push          (push),
      .push_op       (push_op)
   );

   qpd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_op   (head_op)
   );

   qpd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .head_op          (head_op),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_has_data     (rsp_has_data),
      .rsp_bad_pair     (rsp_bad_pair),
      .rsp_chunk_done   (rsp_chunk_done),
      .rsp_chunk_errors (rsp_chunk_errors)
   );

endmodule

### rtl/core/qpd_checker.sv
// Port-level checks for the quoted-printable decoder, bound to the top level.
module qpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_has_data,
   input logic        rsp_bad_pair,
   input logic        rsp_chunk_done,
   input logic [15:0] rsp_chunk_errors
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_chunk_errors))
      else $error("result changed while stalled");

   a_rsp_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_has_data || rsp_bad_pair || rsp_chunk_done)
      else $error("result item with nothing to report");

   a_data_xor_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_has_data && rsp_bad_pair))
      else $error("decoded byte and bad pair in one item");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_data || rsp_out_byte == 8'h00)
         && (rsp_chunk_done || rsp_chunk_errors == 16'h0000))
      else $error("unused result field not zero");

endmodule

bind quoted_printable_decoder_core qpd_checker u_qpd_checker (.*);
